// ===== design/gi2_pkg.sv =====
// shared types and constants for the index stream parser
`default_nettype none

package gi2_pkg;

    localparam int unsigned DataW  = 8;
    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 5;
    localparam int unsigned PathW  = 12;
    localparam int unsigned PadW   = 4;

    localparam logic [31:0] VersionTwo = 32'd2;
    localparam logic [31:0] TreeSig    = 32'h5452_4545;

    localparam logic [7:0] ChNul   = 8'h00;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChNl    = 8'h0a;
    localparam logic [7:0] ChCr    = 8'h0d;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChPlus  = 8'h2b;
    localparam logic [7:0] ChMinus = 8'h2d;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    localparam logic [3:0] ModeFile    = 4'd8;
    localparam logic [3:0] ModeLink    = 4'd10;
    localparam logic [3:0] ModeSubproj = 4'd12;

    // number parse progress
    localparam logic [CountW-1:0] NumLead   = 5'd0;
    localparam logic [CountW-1:0] NumDigits = 5'd1;
    localparam logic [CountW-1:0] NumEnded  = 5'd2;

    typedef enum logic [4:0] {
        PH_SIG     = 5'd0,
        PH_VER     = 5'd1,
        PH_CNT     = 5'd2,
        PH_SKIP    = 5'd3,
        PH_INODE   = 5'd4,
        PH_MODE    = 5'd5,
        PH_IDS     = 5'd6,
        PH_SIZE    = 5'd7,
        PH_HASH    = 5'd8,
        PH_FLAGS   = 5'd9,
        PH_PATH    = 5'd10,
        PH_PAD     = 5'd11,
        PH_EXTSIG  = 5'd12,
        PH_EXTSIZE = 5'd13,
        PH_TPATH   = 5'd14,
        PH_TENT    = 5'd15,
        PH_TSUB    = 5'd16,
        PH_THASH   = 5'd17,
        PH_STOP    = 5'd18
    } t_phase;

    typedef enum logic [3:0] {
        K_HDR_COUNT  = 4'd0,
        K_BAD_VER    = 4'd1,
        K_INODE      = 4'd2,
        K_MODE       = 4'd3,
        K_SIZE       = 4'd4,
        K_HASH       = 4'd5,
        K_PATH       = 4'd6,
        K_ENTRY_DONE = 4'd7,
        K_OTHER_EXT  = 4'd8,
        K_BAD_EXTSZ  = 4'd9,
        K_TREE_PATH  = 4'd10,
        K_TREE_COUNT = 4'd11,
        K_TREE_SUBS  = 4'd12,
        K_TREE_HASH  = 4'd13,
        K_TREE_DONE  = 4'd14,
        K_FINISHED   = 4'd15
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ValueW-1:0]  value;
    } t_result;

endpackage

`default_nettype wire

// ===== design/gi2_parse.sv =====
// parser state and per-word next-state logic
`default_nettype none

module gi2_parse (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [gi2_pkg::DataW-1:0]  i_byte,
    input  wire logic [gi2_pkg::ValueW-1:0] i_file_length,
    output logic                            o_emit,
    output gi2_pkg::t_result                o_res
);
    import gi2_pkg::*;

    t_phase              r_phase, n_phase;
    logic [CountW-1:0]   r_cnt, n_cnt;
    logic [ValueW-1:0]   r_acc, n_acc;
    logic [ValueW-1:0]   r_entries, n_entries;
    logic [PathW-1:0]    r_path, n_path;
    logic [PadW-1:0]     r_pad, n_pad;
    logic [ValueW-1:0]   r_ext, n_ext;
    logic [ValueW-1:0]   r_pos, n_pos;
    logic                r_neg, n_neg;

    logic [ValueW-1:0]   acc_sh;
    logic [CountW-1:0]   cnt_inc;
    logic [ValueW-1:0]   num_val;
    logic [ValueW-1:0]   acc_x10;
    logic [ValueW-1:0]   digit_val;
    logic [ValueW:0]     ext_end;
    logic [2:0]          pad_mod;
    logic [PadW-1:0]     pad_dec;
    logic                is_digit;
    logic                is_blank;
    logic [1:0]          mode_type;

    always_comb begin
        acc_sh    = {r_acc[ValueW-DataW-1:0], i_byte};
        cnt_inc   = r_cnt + 5'd1;
        num_val   = r_neg ? (32'd0 - r_acc) : r_acc;
        digit_val = {24'd0, i_byte - ChZero};
        acc_x10   = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + digit_val;
        is_digit  = (i_byte >= ChZero) && (i_byte <= ChNine);
        is_blank  = (i_byte == ChSpace) || ((i_byte >= ChTab) && (i_byte <= ChCr));
        ext_end   = {1'b0, r_pos + 32'd1} + {1'b0, acc_sh};
        pad_mod   = acc_sh[2:0] + 3'd6;
        pad_dec   = (r_pad != 4'd0) ? (r_pad - 4'd1) : r_pad;
        unique case (acc_sh[15:12])
            ModeFile:    mode_type = 2'd0;
            ModeLink:    mode_type = 2'd1;
            ModeSubproj: mode_type = 2'd2;
            default:     mode_type = 2'd3;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_entries = r_entries;
        n_path    = r_path;
        n_pad     = r_pad;
        n_ext     = r_ext;
        n_pos     = r_pos;
        n_neg     = r_neg;
        o_emit      = 1'b0;
        o_res.kind  = K_HDR_COUNT;
        o_res.value = '0;

        if (i_step && (r_phase != PH_STOP)) begin
            n_pos = r_pos + 32'd1;
            if ((r_phase >= PH_TPATH) && (r_ext != 32'd0)) begin
                n_ext = r_ext - 32'd1;
            end
            unique case (r_phase)
                PH_SIG: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt   = '0;
                        n_phase = PH_VER;
                    end
                end
                PH_VER: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt = '0;
                        if (acc_sh != VersionTwo) begin
                            n_phase     = PH_STOP;
                            o_emit      = 1'b1;
                            o_res.kind  = K_BAD_VER;
                            o_res.value = acc_sh;
                        end else begin
                            n_phase = PH_CNT;
                        end
                    end
                end
                PH_CNT: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt       = '0;
                        n_entries   = acc_sh[31] ? 32'd0 : acc_sh;
                        n_phase     = (!acc_sh[31] && (acc_sh != 32'd0)) ? PH_SKIP
                                                                          : PH_EXTSIG;
                        o_emit      = 1'b1;
                        o_res.kind  = K_HDR_COUNT;
                        o_res.value = acc_sh;
                    end
                end
                PH_SKIP: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd20) begin
                        n_cnt   = '0;
                        n_phase = PH_INODE;
                    end
                end
                PH_INODE: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt       = '0;
                        n_phase     = PH_MODE;
                        o_emit      = 1'b1;
                        o_res.kind  = K_INODE;
                        o_res.value = acc_sh;
                    end
                end
                PH_MODE: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt       = '0;
                        n_phase     = PH_IDS;
                        o_emit      = 1'b1;
                        o_res.kind  = K_MODE;
                        o_res.value = {21'd0, mode_type, acc_sh[8:0]};
                    end
                end
                PH_IDS: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd8) begin
                        n_cnt   = '0;
                        n_phase = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt       = '0;
                        n_phase     = PH_HASH;
                        o_emit      = 1'b1;
                        o_res.kind  = K_SIZE;
                        o_res.value = acc_sh;
                    end
                end
                PH_HASH: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd20) begin
                        n_cnt   = '0;
                        n_phase = PH_FLAGS;
                    end
                    o_emit      = 1'b1;
                    o_res.kind  = K_HASH;
                    o_res.value = {24'd0, i_byte};
                end
                PH_FLAGS: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd2) begin
                        n_cnt   = '0;
                        n_path  = acc_sh[PathW-1:0];
                        n_pad   = 4'd8 - {1'b0, pad_mod};
                        n_phase = (acc_sh[PathW-1:0] != 12'd0) ? PH_PATH : PH_PAD;
                    end
                end
                PH_PATH: begin
                    n_path = r_path - 12'd1;
                    if ((r_path - 12'd1) == 12'd0) begin
                        n_phase = PH_PAD;
                    end
                    o_emit      = 1'b1;
                    o_res.kind  = K_PATH;
                    o_res.value = {24'd0, i_byte};
                end
                PH_PAD: begin
                    n_pad = pad_dec;
                    if (pad_dec == 4'd0) begin
                        n_entries   = r_entries - 32'd1;
                        n_phase     = ((r_entries - 32'd1) != 32'd0) ? PH_SKIP : PH_EXTSIG;
                        o_emit      = 1'b1;
                        o_res.kind  = K_ENTRY_DONE;
                        o_res.value = r_entries - 32'd1;
                    end
                end
                PH_EXTSIG: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt = '0;
                        if (acc_sh != TreeSig) begin
                            n_phase     = PH_STOP;
                            o_emit      = 1'b1;
                            o_res.kind  = K_OTHER_EXT;
                            o_res.value = acc_sh;
                        end else begin
                            n_phase = PH_EXTSIZE;
                        end
                    end
                end
                PH_EXTSIZE: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= 5'd4) begin
                        n_cnt = '0;
                        if (ext_end >= {1'b0, i_file_length}) begin
                            n_phase     = PH_STOP;
                            o_emit      = 1'b1;
                            o_res.kind  = K_BAD_EXTSZ;
                            o_res.value = acc_sh;
                        end else if (acc_sh == 32'd0) begin
                            n_ext       = acc_sh;
                            n_phase     = PH_STOP;
                            o_emit      = 1'b1;
                            o_res.kind  = K_FINISHED;
                            o_res.value = '0;
                        end else begin
                            n_ext   = acc_sh;
                            n_phase = PH_TPATH;
                        end
                    end
                end
                PH_TPATH: begin
                    if (i_byte == ChNul) begin
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_neg   = 1'b0;
                        n_phase = PH_TENT;
                    end else begin
                        o_emit      = 1'b1;
                        o_res.kind  = K_TREE_PATH;
                        o_res.value = {24'd0, i_byte};
                    end
                end
                PH_TENT, PH_TSUB: begin
                    if ((r_phase == PH_TENT) && (i_byte == ChSpace)) begin
                        n_cnt       = '0;
                        n_acc       = '0;
                        n_neg       = 1'b0;
                        n_phase     = PH_TSUB;
                        o_emit      = 1'b1;
                        o_res.kind  = K_TREE_COUNT;
                        o_res.value = num_val;
                    end else if ((r_phase == PH_TSUB) && (i_byte == ChNl)) begin
                        n_cnt       = '0;
                        n_phase     = PH_THASH;
                        o_emit      = 1'b1;
                        o_res.kind  = K_TREE_SUBS;
                        o_res.value = num_val;
                    end else if (r_cnt == NumLead) begin
                        // leading blanks, then sign or first digit; any other byte ends the number
                        priority if (is_blank) begin
                            n_cnt = r_cnt;
                        end else if (i_byte == ChMinus) begin
                            n_neg = 1'b1;
                            n_cnt = NumDigits;
                        end else if (i_byte == ChPlus) begin
                            n_cnt = NumDigits;
                        end else if (is_digit) begin
                            n_acc = digit_val;
                            n_cnt = NumDigits;
                        end else begin
                            n_cnt = NumEnded;
                        end
                    end else if (r_cnt == NumDigits) begin
                        if (is_digit) begin
                            n_acc = acc_x10;
                        end else begin
                            n_cnt = NumEnded;
                        end
                    end
                end
                PH_THASH: begin
                    o_emit      = 1'b1;
                    o_res.value = {24'd0, i_byte};
                    if (cnt_inc < 5'd20) begin
                        n_cnt      = cnt_inc;
                        o_res.kind = K_TREE_HASH;
                    end else begin
                        n_cnt = '0;
                        if (n_ext == 32'd0) begin
                            n_phase    = PH_STOP;
                            o_res.kind = K_FINISHED;
                        end else begin
                            n_phase    = PH_TPATH;
                            o_res.kind = K_TREE_DONE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIG;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_entries <= '0;
            r_path    <= '0;
            r_pad     <= '0;
            r_ext     <= '0;
            r_pos     <= '0;
            r_neg     <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_entries <= n_entries;
            r_path    <= n_path;
            r_pad     <= n_pad;
            r_ext     <= n_ext;
            r_pos     <= n_pos;
            r_neg     <= n_neg;
        end
    end

endmodule

`default_nettype wire

// ===== design/gi2_out_reg.sv =====
// result register towards the receiver
`default_nettype none

module gi2_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire gi2_pkg::t_result    i_res,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output gi2_pkg::t_result         o_res
);
    import gi2_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== design/git_index_v2_stream_parser.sv =====
// top level of the version-2 index file stream parser
//
// input channel: one file byte per word on i_data_byte, handshake
// i_data_valid / o_data_ready. output channel: one tagged result per word
// on o_kind / o_value, handshake o_res_valid / i_res_ready. bytes that
// produce no result are consumed silently.
// file_length is written through i_file_length_we / i_file_length; the user
// must write it only while idle; the block does not enforce it. bytes go
// into the input register, then their results into the result register.
// throughput: one byte per cycle while the receiver keeps i_res_ready high;
// the per-byte work is one pass of the parser's next-state logic.
// reset: synchronous, active low; clears parser state, file_length and both
// valid flags, and the parser waits for the header signature.
// receiver stall: the result register holds its word, the held input byte
// waits, and o_data_ready drops once the input register is occupied.
// after a stop condition every further byte is accepted and dropped.
`default_nettype none

module git_index_v2_stream_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_data_valid,
    output logic                             o_data_ready,
    input  wire logic [gi2_pkg::DataW-1:0]   i_data_byte,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output logic [3:0]                       o_kind,
    output logic [gi2_pkg::ValueW-1:0]       o_value,
    input  wire logic                        i_file_length_we,
    input  wire logic [gi2_pkg::ValueW-1:0]  i_file_length
);
    import gi2_pkg::*;

    logic               r_in_valid;
    logic [DataW-1:0]   r_in_byte;
    logic [ValueW-1:0]  r_file_length;
    logic               step;
    logic               emit;
    t_result            step_res;
    t_result            out_res;

    assign step         = r_in_valid && (!o_res_valid || i_res_ready);
    assign o_data_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_file_length <= '0;
        end else begin
            if (o_data_ready) begin
                r_in_valid <= i_data_valid;
            end
            if (i_file_length_we) begin
                r_file_length <= i_file_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_data_ready && i_data_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    gi2_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_file_length (r_file_length),
        .o_emit        (emit),
        .o_res         (step_res)
    );

    gi2_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && emit),
        .i_res   (step_res),
        .i_ready (i_res_ready),
        .o_valid (o_res_valid),
        .o_res   (out_res)
    );

    assign o_kind  = out_res.kind;
    assign o_value = out_res.value;

endmodule

`default_nettype wire

// ===== design/gi2_checker.sv =====
// port-level checks for the index stream parser, bound to the top level
`default_nettype none

module gi2_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_res_valid,
    input  wire logic                        i_res_ready,
    input  wire logic [3:0]                  o_kind,
    input  wire logic [gi2_pkg::ValueW-1:0]  o_value
);
    import gi2_pkg::*;

    // result word holds while the receiver stalls
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result word dropped under stall");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> $stable(o_kind) && $stable(o_value))
        else $error("result word changed under stall");

    // nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // byte-valued results and mode results stay narrow
    a_byte_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind == K_HASH || o_kind == K_PATH ||
                        o_kind == K_TREE_PATH || o_kind == K_TREE_HASH ||
                        o_kind == K_TREE_DONE)
        |-> o_value[31:8] == 24'd0)
        else $error("byte result wider than a byte");

    a_mode_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind == K_MODE) |-> o_value[31:11] == 21'd0)
        else $error("mode result out of range");

endmodule

bind git_index_v2_stream_parser gi2_checker u_gi2_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_kind      (o_kind),
    .o_value     (o_value)
);

`default_nettype wire

// ===== dv/gi2_tb_pkg.sv =====
// scoreboard for the index stream parser: byte-level field predictor and result check
`timescale 1ns / 1ps

package gi2_tb_pkg;
    import gi2_pkg::*;

    localparam logic [1:0] TypeFile    = 2'd0;
    localparam logic [1:0] TypeLink    = 2'd1;
    localparam logic [1:0] TypeSubproj = 2'd2;
    localparam logic [1:0] TypeUnknown = 2'd3;

    class index_field_check;
        t_phase              phase;
        logic [CountW-1:0]   nbytes;
        logic [31:0]         acc;
        logic [31:0]         entries_left;
        logic [PathW-1:0]    path_left;
        logic [PadW-1:0]     pad_left;
        logic [31:0]         ext_left;
        logic [31:0]         byte_pos;
        logic [31:0]         total_len;
        bit                  negative;
        t_result             expected_fields[$];
        int unsigned         errors;

        function new();
            phase        = PH_SIG;
            nbytes       = '0;
            acc          = '0;
            entries_left = '0;
            path_left    = '0;
            pad_left     = '0;
            ext_left     = '0;
            byte_pos     = '0;
            total_len    = '0;
            negative     = 1'b0;
            errors       = 0;
        endfunction

        function void set_file_length(logic [31:0] v);
            total_len = v;
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        function logic [31:0] position();
            return byte_pos;
        endfunction

        function void push_field(t_kind k, logic [31:0] v);
            t_result r;
            r.kind  = k;
            r.value = v;
            expected_fields.push_back(r);
        endfunction

        function bit count_up(int n);
            nbytes++;
            if (nbytes >= n) begin
                nbytes = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit shift_in(logic [7:0] b, int n);
            acc = {acc[23:0], b};
            return count_up(n);
        endfunction

        function void number_clear();
            nbytes   = NumLead;
            acc      = '0;
            negative = 1'b0;
        endfunction

        function logic [31:0] number_result();
            return negative ? 32'd0 - acc : acc;
        endfunction

        function void number_take(logic [7:0] b);
            bit digit;
            digit = (b >= ChZero) && (b <= ChNine);
            if (nbytes == NumLead) begin
                if (b == ChSpace || (b >= ChTab && b <= ChCr))
                    return;
                if (b == ChMinus) begin
                    negative = 1'b1;
                    nbytes   = NumDigits;
                end else if (b == ChPlus) begin
                    nbytes = NumDigits;
                end else if (digit) begin
                    acc    = {24'd0, b - ChZero};
                    nbytes = NumDigits;
                end else begin
                    nbytes = NumEnded;
                end
            end else if (nbytes == NumDigits) begin
                if (digit)
                    acc = acc * 32'd10 + {24'd0, b - ChZero};
                else
                    nbytes = NumEnded;
            end
        endfunction

        function void note_byte(logic [7:0] b);
            logic [3:0]  mode_nib;
            logic [1:0]  type_code;
            logic [31:0] num;
            if (phase == PH_STOP)
                return;
            byte_pos++;
            if (phase >= PH_TPATH && ext_left != 0)
                ext_left--;
            case (phase)
                PH_SIG: begin
                    if (count_up(4))
                        phase = PH_VER;
                end
                PH_VER: begin
                    if (shift_in(b, 4)) begin
                        if (acc != VersionTwo) begin
                            phase = PH_STOP;
                            push_field(K_BAD_VER, acc);
                        end else begin
                            phase = PH_CNT;
                        end
                    end
                end
                PH_CNT: begin
                    if (shift_in(b, 4)) begin
                        entries_left = acc[31] ? 32'd0 : acc;
                        phase = (entries_left != 0) ? PH_SKIP : PH_EXTSIG;
                        push_field(K_HDR_COUNT, acc);
                    end
                end
                PH_SKIP: begin
                    if (count_up(20))
                        phase = PH_INODE;
                end
                PH_INODE: begin
                    if (shift_in(b, 4)) begin
                        phase = PH_MODE;
                        push_field(K_INODE, acc);
                    end
                end
                PH_MODE: begin
                    if (shift_in(b, 4)) begin
                        phase    = PH_IDS;
                        mode_nib = acc[15:12];
                        if (mode_nib == ModeFile)
                            type_code = TypeFile;
                        else if (mode_nib == ModeLink)
                            type_code = TypeLink;
                        else if (mode_nib == ModeSubproj)
                            type_code = TypeSubproj;
                        else
                            type_code = TypeUnknown;
                        push_field(K_MODE, {21'd0, type_code, acc[8:0]});
                    end
                end
                PH_IDS: begin
                    if (count_up(8))
                        phase = PH_SIZE;
                end
                PH_SIZE: begin
                    if (shift_in(b, 4)) begin
                        phase = PH_HASH;
                        push_field(K_SIZE, acc);
                    end
                end
                PH_HASH: begin
                    if (count_up(20))
                        phase = PH_FLAGS;
                    push_field(K_HASH, {24'd0, b});
                end
                PH_FLAGS: begin
                    if (shift_in(b, 2)) begin
                        path_left = acc[11:0];
                        pad_left  = 4'(8 - ((62 + path_left) % 8));
                        phase = (path_left != 0) ? PH_PATH : PH_PAD;
                    end
                end
                PH_PATH: begin
                    path_left = path_left - 12'd1;
                    if (path_left == 0)
                        phase = PH_PAD;
                    push_field(K_PATH, {24'd0, b});
                end
                PH_PAD: begin
                    if (pad_left != 0)
                        pad_left--;
                    if (pad_left == 0) begin
                        entries_left--;
                        phase = (entries_left != 0) ? PH_SKIP : PH_EXTSIG;
                        push_field(K_ENTRY_DONE, entries_left);
                    end
                end
                PH_EXTSIG: begin
                    if (shift_in(b, 4)) begin
                        if (acc != TreeSig) begin
                            phase = PH_STOP;
                            push_field(K_OTHER_EXT, acc);
                        end else begin
                            phase = PH_EXTSIZE;
                        end
                    end
                end
                PH_EXTSIZE: begin
                    if (shift_in(b, 4)) begin
                        if ({1'b0, byte_pos} + {1'b0, acc} >= {1'b0, total_len}) begin
                            phase = PH_STOP;
                            push_field(K_BAD_EXTSZ, acc);
                        end else begin
                            ext_left = acc;
                            if (acc == 0) begin
                                phase = PH_STOP;
                                push_field(K_FINISHED, 32'd0);
                            end else begin
                                phase = PH_TPATH;
                            end
                        end
                    end
                end
                PH_TPATH: begin
                    if (b == ChNul) begin
                        number_clear();
                        phase = PH_TENT;
                    end else begin
                        push_field(K_TREE_PATH, {24'd0, b});
                    end
                end
                PH_TENT: begin
                    if (b == ChSpace) begin
                        num = number_result();
                        number_clear();
                        phase = PH_TSUB;
                        push_field(K_TREE_COUNT, num);
                    end else begin
                        number_take(b);
                    end
                end
                PH_TSUB: begin
                    if (b == ChNl) begin
                        num    = number_result();
                        nbytes = '0;
                        phase  = PH_THASH;
                        push_field(K_TREE_SUBS, num);
                    end else begin
                        number_take(b);
                    end
                end
                PH_THASH: begin
                    if (!count_up(20)) begin
                        push_field(K_TREE_HASH, {24'd0, b});
                    end else if (ext_left == 0) begin
                        phase = PH_STOP;
                        push_field(K_FINISHED, {24'd0, b});
                    end else begin
                        phase = PH_TPATH;
                        push_field(K_TREE_DONE, {24'd0, b});
                    end
                end
                default: begin
                    phase = PH_STOP;
                end
            endcase
        endfunction

        function void complain(string what, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        endfunction

        function void check_field(logic [3:0] kind, logic [31:0] value);
            t_result want;
            if (expected_fields.size() == 0) begin
                $display("%0t: result with nothing expected, kind %0d value %0h",
                         $time, kind, value);
                errors++;
                return;
            end
            want = expected_fields.pop_front();
            if (kind !== want.kind)
                complain("kind", {28'd0, want.kind}, {28'd0, kind});
            if (value !== want.value)
                complain("value", want.value, value);
        endfunction
    endclass

endpackage

// ===== dv/testbench.sv =====
// top of the index stream parser testbench: clock, reset, byte stimulus and result check
`timescale 1ns / 1ps

module testbench;
    import gi2_pkg::*;
    import gi2_tb_pkg::*;

    localparam int unsigned CycleLimit   = 500000;
    localparam int          SettleCycles = 6;
    localparam int          HoldCycles   = 400;
    localparam int          EntryCount   = 5;
    localparam int          RecordCount  = 4;

    typedef enum int {GapsSendLow, GapsSendHigh, GapsNone} t_gaps;
    typedef enum int {CountRandom, CountNegative, CountLong, CountEmpty} t_count_style;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_data_valid     = 1'b0;
    logic [7:0]  i_data_byte      = '0;
    logic        i_res_ready      = 1'b0;
    logic        i_file_length_we = 1'b0;
    logic [31:0] i_file_length    = '0;
    logic        o_data_ready;
    logic        o_res_valid;
    logic [3:0]  o_kind;
    logic [31:0] o_value;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    logic [7:0]  tree_image[$];
    int          record_len[$];

    index_field_check field_check = new();

    git_index_v2_stream_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_data_valid     (i_data_valid),
        .o_data_ready     (o_data_ready),
        .i_data_byte      (i_data_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_kind           (o_kind),
        .o_value          (o_value),
        .i_file_length_we (i_file_length_we),
        .i_file_length    (i_file_length)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            field_check.check_field(o_kind, o_value);
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                i_res_ready <= 1'b0;
                hold_left--;
            end else begin
                i_res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void set_gaps(t_gaps g);
        case (g)
            GapsSendLow: begin
                send_idle_pct = 22;
                recv_idle_pct = 50;
            end
            GapsSendHigh: begin
                send_idle_pct = 50;
                recv_idle_pct = 22;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_data_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data_valid <= 1'b1;
        i_data_byte  <= b;
        do @(posedge i_clk); while (!o_data_ready);
        field_check.note_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_be(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_byte(v[8*i +: 8]);
    endtask

    task automatic send_entry(input logic [31:0] inode, input logic [31:0] mode,
                              input logic [31:0] size, input logic [15:0] flags);
        int path_len;
        path_len = flags[11:0];
        repeat (20) send_byte(8'($urandom));
        send_be(inode, 4);
        send_be(mode, 4);
        repeat (8) send_byte(8'($urandom));
        send_be(size, 4);
        repeat (20) send_byte(8'($urandom));
        send_be({16'd0, flags}, 2);
        repeat (path_len) send_byte(8'($urandom));
        repeat (8 - (62 + path_len) % 8) send_byte(8'($urandom));
    endtask

    task automatic write_file_length(input logic [31:0] v);
        i_file_length_we <= 1'b1;
        i_file_length    <= v;
        field_check.set_file_length(v);
        @(negedge i_clk);
        i_file_length_we <= 1'b0;
    endtask

    task automatic wait_idle();
        i_data_valid <= 1'b0;
        while (field_check.pending() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // decimal count text: optional whitespace, sign, digits, trailing junk, terminator
    function automatic void push_count(bit subtree, t_count_style style);
        logic [7:0] term;
        logic [7:0] c;
        int         nlead;
        int         sgn;
        int         ndig;
        int         njunk;
        term  = subtree ? ChNl : ChSpace;
        nlead = $urandom_range(0, 2);
        sgn   = $urandom_range(0, 3);
        ndig  = $urandom_range(1, 4);
        njunk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        case (style)
            CountNegative: sgn = 0;
            CountLong:     ndig = 12;
            CountEmpty: begin
                ndig  = 0;
                njunk = 0;
            end
            default: ;
        endcase
        repeat (nlead) begin
            c = ChTab + 8'($urandom_range(0, 4));
            if (c == term)
                c = subtree ? ChSpace : ChCr;
            tree_image.push_back(c);
        end
        if (sgn == 0)
            tree_image.push_back(ChMinus);
        else if (sgn == 1)
            tree_image.push_back(ChPlus);
        repeat (ndig) tree_image.push_back(ChZero + 8'($urandom_range(0, 9)));
        repeat (njunk) begin
            c = 8'($urandom);
            tree_image.push_back((c == term) ? ChMinus : c);
        end
        tree_image.push_back(term);
    endfunction

    function automatic void build_record(t_count_style style);
        int start;
        int plen;
        start = tree_image.size();
        plen  = (style == CountNegative) ? 0 : $urandom_range(0, 6);
        repeat (plen) tree_image.push_back(8'($urandom_range(1, 255)));
        tree_image.push_back(ChNul);
        push_count(1'b0, style);
        push_count(1'b1, style);
        repeat (20) tree_image.push_back(8'($urandom));
        record_len.push_back(tree_image.size() - start);
    endfunction

    initial begin
        logic [3:0]  mode_nib;
        logic [11:0] plen;
        logic [31:0] tree_size;
        int          overrun;
        int          base;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_file_length(32'd0);

        // header, signature bytes unchecked
        set_gaps(GapsSendLow);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h5a);
        send_byte(8'ha5);
        send_be(VersionTwo, 4);
        send_be(EntryCount, 4);

        // each file type, field extremes, pad of 2, 1, 8 and 3 bytes
        set_gaps(GapsSendHigh);
        send_entry(32'h0000_0000, 32'h0000_81a4, 32'h0000_0000, 16'h0000);
        set_gaps(GapsNone);
        send_entry(32'hffff_ffff, 32'h0000_a1ff, 32'hffff_ffff, 16'hf001);
        set_gaps(GapsSendLow);
        send_entry(32'h1234_5678, 32'hffff_c1ed, 32'h8000_0000, 16'h0002);
        set_gaps(GapsSendHigh);
        send_entry(32'h8000_0001, 32'h0000_43ff, 32'h7fff_ffff, 16'h0007);
        wait_idle();
        write_file_length(32'hffff_ffff);

        // first random entry carries the long receiver stall
        for (int i = 4; i < EntryCount; i++) begin
            set_gaps(t_gaps'(i % 3));
            case ($urandom_range(0, 3))
                0:       mode_nib = ModeFile;
                1:       mode_nib = ModeLink;
                2:       mode_nib = ModeSubproj;
                default: mode_nib = 4'($urandom);
            endcase
            plen = 12'($urandom_range(1, 40));
            if (i == 4)
                hold_req = 1'b1;
            send_entry($urandom, {16'($urandom), mode_nib, 12'($urandom)}, $urandom,
                       {4'($urandom), plen});
            if (i == 6) begin
                wait_idle();
                write_file_length($urandom);
            end
        end

        // tree extension, sometimes declared shorter than its last record
        for (int r = 0; r < RecordCount; r++)
            build_record((r < 4) ? t_count_style'(r) : CountRandom);
        overrun = ($urandom_range(0, 1) == 0) ? 0 :
                  $urandom_range(0, record_len[record_len.size() - 1] - 1);
        tree_size = tree_image.size() - overrun;
        wait_idle();
        // just inside the extension size check
        write_file_length(field_check.position() + 32'd9 + tree_size);
        set_gaps(GapsSendLow);
        send_be(TreeSig, 4);
        send_be(tree_size, 4);
        base = 0;
        for (int r = 0; r < RecordCount; r++) begin
            set_gaps(t_gaps'(r % 3));
            for (int j = 0; j < record_len[r]; j++)
                send_byte(tree_image[base + j]);
            base += record_len[r];
        end

        // bytes after the stop are dropped
        set_gaps(GapsSendLow);
        repeat (8) send_byte(8'($urandom));
        wait_idle();

        if (field_check.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
